[rtl/core/lbachs_pkg.sv]
// Shared types and constants of the LBA to CHS request converter.
`default_nettype none
package lbachs_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_CYLINDERS  = 3'd0;
    localparam logic [2:0] CFG_HEADS      = 3'd1;
    localparam logic [2:0] CFG_SPT        = 3'd2;
    localparam logic [2:0] CFG_PART_START = 3'd3;
    localparam logic [2:0] CFG_PART_SIZE  = 3'd4;
    localparam logic [2:0] CFG_DRIVE      = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_PART = 2'd1;
    localparam logic [1:0] STATUS_GEOM = 2'd2;

    // Geometry limits used by the BIOS CHS interface
    localparam logic [10:0] MAX_CYLINDERS = 11'd1024;
    localparam logic [8:0]  MAX_HEADS     = 9'd256;

    // Reset values of the configuration registers
    localparam logic [10:0] RST_CYLINDERS = 11'd1024;
    localparam logic [8:0]  RST_HEADS     = 9'd16;
    localparam logic [5:0]  RST_SPT       = 6'd63;
    localparam logic [7:0]  RST_DRIVE     = 8'd128;

    // Widths of the divider chains
    localparam int ABS_W  = 24;   // absolute LBA below capacity
    localparam int PCYL_W = 14;   // heads * sectors per track
    localparam int SPT_W  = 6;
    localparam int CYL_W  = 10;
    localparam int HEAD_W = 8;

    // Geometry as seen by the datapath, clamped to the CHS limits
    typedef struct packed {
        logic [10:0] cyls;
        logic [8:0]  heads;
        logic [5:0]  spt;
        logic [31:0] part_start;
        logic [31:0] part_size;
    } geom_t;

    // Request fields that ride along the pipeline
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [7:0]  count;
        logic [15:0] seg;
        logic [15:0] off;
    } req_info_t;

    // Sideband of the cylinder divider chain
    typedef struct packed {
        req_info_t        info;
        logic [SPT_W-1:0] spt;
    } cyl_side_t;

    // Sideband of the head divider chain
    typedef struct packed {
        req_info_t        info;
        logic [CYL_W-1:0] cyl;
    } head_side_t;

endpackage
`default_nettype wire

[rtl/core/lbachs_div_cell.sv]
// One restoring-division cell: one quotient bit per stage, with valid/ready.
`default_nettype none
module lbachs_div_cell #(
    parameter int RW    = 24,
    parameter int DW    = 14,
    parameter int QW    = 10,
    parameter int SHIFT = 0,
    parameter int SW    = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [RW-1:0] in_rem,
    input  wire logic [DW-1:0] in_div,
    input  wire logic [QW-1:0] in_quot,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [RW-1:0]      out_rem,
    output logic [DW-1:0]      out_div,
    output logic [QW-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);
    localparam int TW = RW + DW;

    logic          valid_reg;
    logic [RW-1:0] rem_reg,  rem_next;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] quot_reg, quot_next;
    logic [SW-1:0] side_reg;
    logic [TW-1:0] trial;
    logic [TW-1:0] wide_rem;
    logic          fits;

    // Trial subtract of the shifted divisor
    always_comb
    begin
        trial     = TW'(in_div) << SHIFT;
        wide_rem  = TW'(in_rem);
        fits      = (wide_rem >= trial);
        rem_next  = fits ? RW'(wide_rem - trial) : in_rem;
        quot_next = in_quot;
        quot_next[SHIFT] = fits;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            div_reg  <= in_div;
            quot_reg <= quot_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quot  = quot_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

[rtl/core/lbachs_check.sv]
// Front stages: range checks, absolute address and per-cylinder size.
`default_nettype none
module lbachs_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lbachs_pkg::geom_t             geom,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    kind,
    input  wire logic [31:0]                   block_address,
    input  wire logic [7:0]                    sector_total,
    input  wire logic [15:0]                   buffer_segment,
    input  wire logic [15:0]                   buffer_offset,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lbachs_pkg::cyl_side_t              out_side,
    output logic [lbachs_pkg::ABS_W-1:0]       out_abs,
    output logic [lbachs_pkg::PCYL_W-1:0]      out_per_cyl
);
    import lbachs_pkg::*;

    // First stage: sums and per-cylinder product
    logic              a_valid_reg;
    logic              a_ready;
    req_info_t         a_info_reg;
    logic              a_part_fail_reg;
    logic [32:0]       a_abs_reg;
    logic [PCYL_W-1:0] a_per_cyl_reg;
    logic [10:0]       a_cyls_reg;
    logic [5:0]        a_spt_reg;

    logic [32:0]       end_addr;
    logic [14:0]       per_cyl_prod;

    // Second stage: capacity compare
    logic              b_valid_reg;
    cyl_side_t         b_side_reg;
    logic [ABS_W-1:0]  b_abs_reg;
    logic [PCYL_W-1:0] b_per_cyl_reg;

    logic [24:0]       capacity;
    logic [1:0]        status_next;
    req_info_t         b_info_next;

    always_comb
    begin
        end_addr     = {1'b0, block_address} + 33'(sector_total);
        per_cyl_prod = geom.heads * geom.spt;
    end

    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_info_reg.status <= STATUS_OK;
            a_info_reg.kind   <= kind;
            a_info_reg.count  <= sector_total;
            a_info_reg.seg    <= buffer_segment;
            a_info_reg.off    <= buffer_offset;
            a_part_fail_reg   <= (end_addr > {1'b0, geom.part_size});
            a_abs_reg         <= {1'b0, block_address} + {1'b0, geom.part_start};
            a_per_cyl_reg     <= per_cyl_prod[PCYL_W-1:0];
            a_cyls_reg        <= geom.cyls;
            a_spt_reg         <= geom.spt;
        end
    end

    always_comb
    begin
        capacity = a_cyls_reg * a_per_cyl_reg;
        if (a_part_fail_reg)
        begin
            status_next = STATUS_PART;
        end
        else if ((capacity == 25'd0) || (a_abs_reg >= 33'(capacity)))
        begin
            status_next = STATUS_GEOM;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        b_info_next        = a_info_reg;
        b_info_next.status = status_next;
    end

    assign a_ready = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_valid_reg)
        begin
            b_side_reg.info <= b_info_next;
            b_side_reg.spt  <= a_spt_reg;
            b_abs_reg       <= a_abs_reg[ABS_W-1:0];
            b_per_cyl_reg   <= a_per_cyl_reg;
        end
    end

    assign out_valid   = b_valid_reg;
    assign out_side    = b_side_reg;
    assign out_abs     = b_abs_reg;
    assign out_per_cyl = b_per_cyl_reg;

endmodule
`default_nettype wire

[rtl/core/lba_to_chs_int13_request.sv]
// LBA to CHS converter. Throughput one request per cycle while the response
// side accepts; two check stages, ten cylinder divider cells (one quotient
// bit each), eight head divider cells and an output register.
// Reset: pipeline empties; geometry 1024/16/63, partition start and size 0,
// drive 0x80.
`default_nettype none
module lba_to_chs_int13_request (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // request channel
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  sector_total,
    input  wire logic [15:0] buffer_segment,
    input  wire logic [15:0] buffer_offset,
    // response channel
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [1:0]       status,
    output logic [9:0]       cylinder,
    output logic [7:0]       head,
    output logic [5:0]       sector,
    output logic [15:0]      reg_ax,
    output logic [15:0]      reg_cx,
    output logic [15:0]      reg_dx,
    output logic [15:0]      reg_es,
    output logic [15:0]      reg_bx
);
    import lbachs_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [10:0] cyl_count_reg;
    logic [8:0]  head_count_reg;
    logic [5:0]  spt_reg;
    logic [31:0] part_start_reg;
    logic [31:0] part_size_reg;
    logic [7:0]  drive_reg;
    geom_t       geom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_count_reg  <= RST_CYLINDERS;
            head_count_reg <= RST_HEADS;
            spt_reg        <= RST_SPT;
            part_start_reg <= '0;
            part_size_reg  <= '0;
            drive_reg      <= RST_DRIVE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CYLINDERS:  cyl_count_reg  <= cfg_data[10:0];
                CFG_HEADS:      head_count_reg <= cfg_data[8:0];
                CFG_SPT:        spt_reg        <= cfg_data[5:0];
                CFG_PART_START: part_start_reg <= cfg_data;
                CFG_PART_SIZE:  part_size_reg  <= cfg_data;
                CFG_DRIVE:      drive_reg      <= cfg_data[7:0];
                default:        ;   // drop writes to unused indexes
            endcase
        end
    end

    // Clamp oversized geometry so cylinder and head always fit their fields
    always_comb
    begin
        geom.cyls       = (cyl_count_reg > MAX_CYLINDERS) ? MAX_CYLINDERS : cyl_count_reg;
        geom.heads      = (head_count_reg > MAX_HEADS) ? MAX_HEADS : head_count_reg;
        geom.spt        = spt_reg;
        geom.part_start = part_start_reg;
        geom.part_size  = part_size_reg;
    end

    // ------------------------------------------------------------------
    // Front: partition check, absolute address, capacity check
    // ------------------------------------------------------------------
    logic              c_valid [0:CYL_W];
    logic              c_ready [0:CYL_W];
    logic [ABS_W-1:0]  c_rem   [0:CYL_W];
    logic [PCYL_W-1:0] c_div   [0:CYL_W];
    logic [CYL_W-1:0]  c_quot  [0:CYL_W];
    cyl_side_t         c_side  [0:CYL_W];

    lbachs_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .geom           (geom),
        .in_valid       (req_valid),
        .in_ready       (req_ready),
        .kind           (kind),
        .block_address  (block_address),
        .sector_total   (sector_total),
        .buffer_segment (buffer_segment),
        .buffer_offset  (buffer_offset),
        .out_valid      (c_valid[0]),
        .out_ready      (c_ready[0]),
        .out_side       (c_side[0]),
        .out_abs        (c_rem[0]),
        .out_per_cyl    (c_div[0])
    );

    assign c_quot[0] = '0;

    // ------------------------------------------------------------------
    // Cylinder chain: abs / (heads * spt), most significant bit first.
    // The capacity check guarantees the quotient fits ten bits.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CYL_W; i++)
    begin : g_cyl
        lbachs_div_cell #(
            .RW    (ABS_W),
            .DW    (PCYL_W),
            .QW    (CYL_W),
            .SHIFT (CYL_W - 1 - i),
            .SW    ($bits(cyl_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_rem    (c_rem[i]),
            .in_div    (c_div[i]),
            .in_quot   (c_quot[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_div   (c_div[i+1]),
            .out_quot  (c_quot[i+1]),
            .out_side  (c_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Head chain: remainder / spt; the final remainder is the sector index.
    // ------------------------------------------------------------------
    logic              h_valid [0:HEAD_W];
    logic              h_ready [0:HEAD_W];
    logic [PCYL_W-1:0] h_rem   [0:HEAD_W];
    logic [SPT_W-1:0]  h_div   [0:HEAD_W];
    logic [HEAD_W-1:0] h_quot  [0:HEAD_W];
    head_side_t        h_side  [0:HEAD_W];

    // Hand the cylinder quotient over into the head chain sideband
    assign h_valid[0]     = c_valid[CYL_W];
    assign c_ready[CYL_W] = h_ready[0];
    assign h_rem[0]       = c_rem[CYL_W][PCYL_W-1:0];
    assign h_div[0]       = c_side[CYL_W].spt;
    assign h_quot[0]      = '0;
    assign h_side[0].info = c_side[CYL_W].info;
    assign h_side[0].cyl  = c_quot[CYL_W];

    for (genvar j = 0; j < HEAD_W; j++)
    begin : g_head
        lbachs_div_cell #(
            .RW    (PCYL_W),
            .DW    (SPT_W),
            .QW    (HEAD_W),
            .SHIFT (HEAD_W - 1 - j),
            .SW    ($bits(head_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (h_valid[j]),
            .in_ready  (h_ready[j]),
            .in_rem    (h_rem[j]),
            .in_div    (h_div[j]),
            .in_quot   (h_quot[j]),
            .in_side   (h_side[j]),
            .out_valid (h_valid[j+1]),
            .out_ready (h_ready[j+1]),
            .out_rem   (h_rem[j+1]),
            .out_div   (h_div[j+1]),
            .out_quot  (h_quot[j+1]),
            .out_side  (h_side[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: pack the INT 13h register image, zero on failure
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    logic        out_load;
    logic        pass;
    req_info_t   fin_info;
    logic [9:0]  fin_cyl;
    logic [7:0]  fin_head;
    logic [5:0]  fin_sec;

    logic [1:0]  status_reg;
    logic [9:0]  cylinder_reg,  cylinder_next;
    logic [7:0]  head_reg,      head_next;
    logic [5:0]  sector_reg,    sector_next;
    logic [15:0] reg_ax_reg,    reg_ax_next;
    logic [15:0] reg_cx_reg,    reg_cx_next;
    logic [15:0] reg_dx_reg,    reg_dx_next;
    logic [15:0] reg_es_reg,    reg_es_next;
    logic [15:0] reg_bx_reg,    reg_bx_next;

    always_comb
    begin
        fin_info = h_side[HEAD_W].info;
        fin_cyl  = h_side[HEAD_W].cyl;
        fin_head = h_quot[HEAD_W];
        fin_sec  = h_rem[HEAD_W][SPT_W-1:0] + 6'd1;
        pass     = (fin_info.status == STATUS_OK);

        cylinder_next = pass ? fin_cyl  : '0;
        head_next     = pass ? fin_head : '0;
        sector_next   = pass ? fin_sec  : '0;
        reg_ax_next   = pass ? {5'd0, fin_info.kind, fin_info.count} : '0;
        reg_cx_next   = pass ? {fin_cyl[7:0], fin_cyl[9:8], fin_sec} : '0;
        reg_dx_next   = pass ? {fin_head, drive_reg} : '0;
        reg_es_next   = pass ? fin_info.seg : '0;
        reg_bx_next   = pass ? fin_info.off : '0;
    end

    // Advance the last cell whenever the output register is free or draining
    assign h_ready[HEAD_W] = !out_valid_reg || rsp_ready;
    assign out_load        = h_ready[HEAD_W] && h_valid[HEAD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (h_ready[HEAD_W])
        begin
            out_valid_reg <= h_valid[HEAD_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg   <= fin_info.status;
            cylinder_reg <= cylinder_next;
            head_reg     <= head_next;
            sector_reg   <= sector_next;
            reg_ax_reg   <= reg_ax_next;
            reg_cx_reg   <= reg_cx_next;
            reg_dx_reg   <= reg_dx_next;
            reg_es_reg   <= reg_es_next;
            reg_bx_reg   <= reg_bx_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = status_reg;
    assign cylinder  = cylinder_reg;
    assign head      = head_reg;
    assign sector    = sector_reg;
    assign reg_ax    = reg_ax_reg;
    assign reg_cx    = reg_cx_reg;
    assign reg_dx    = reg_dx_reg;
    assign reg_es    = reg_es_reg;
    assign reg_bx    = reg_bx_reg;

endmodule
`default_nettype wire

[tb/chs_request_checker.sv]
// Scoreboard for the LBA to CHS converter: predicts each response beat and compares it.
`default_nettype none
module chs_request_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        req_valid,
    input  wire logic        req_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  sector_total,
    input  wire logic [15:0] buffer_segment,
    input  wire logic [15:0] buffer_offset,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_ready,
    input  wire logic [1:0]  status,
    input  wire logic [9:0]  cylinder,
    input  wire logic [7:0]  head,
    input  wire logic [5:0]  sector,
    input  wire logic [15:0] reg_ax,
    input  wire logic [15:0] reg_cx,
    input  wire logic [15:0] reg_dx,
    input  wire logic [15:0] reg_es,
    input  wire logic [15:0] reg_bx,
    output int               pending,
    output int               failures
);
    import lbachs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  cylinder;
        logic [7:0]  head;
        logic [5:0]  sector;
        logic [15:0] reg_ax;
        logic [15:0] reg_cx;
        logic [15:0] reg_dx;
        logic [15:0] reg_es;
        logic [15:0] reg_bx;
    } chs_image_t;

    // Local copy of the geometry and partition registers
    logic [10:0] cyl_cfg;
    logic [8:0]  head_cfg;
    logic [5:0]  spt_cfg;
    logic [31:0] start_cfg;
    logic [31:0] size_cfg;
    logic [7:0]  drive_cfg;

    chs_image_t expected_chs_q[$];
    chs_image_t oldest;

    function automatic chs_image_t lba_to_chs_image(input logic [2:0]  op,
                                                    input logic [31:0] lba,
                                                    input logic [7:0]  cnt,
                                                    input logic [15:0] seg,
                                                    input logic [15:0] off);
        logic [32:0] last_lba;
        logic [32:0] abs_lba;
        logic [10:0] cyls;
        logic [8:0]  heads;
        int unsigned per_cyl;
        int unsigned capacity;
        int unsigned cyl;
        int unsigned rem;
        int unsigned hd;
        int unsigned sec;
        chs_image_t  img;
        img      = '0;
        last_lba = {1'b0, lba} + {25'd0, cnt};
        abs_lba  = {1'b0, lba} + {1'b0, start_cfg};
        // clamp to what the CHS register layout can carry
        cyls     = (cyl_cfg > MAX_CYLINDERS) ? MAX_CYLINDERS : cyl_cfg;
        heads    = (head_cfg > MAX_HEADS) ? MAX_HEADS : head_cfg;
        per_cyl  = heads * spt_cfg;
        capacity = cyls * per_cyl;
        if (last_lba > {1'b0, size_cfg})
            img.status = STATUS_PART;
        else if (capacity == 0 || abs_lba >= {1'b0, capacity})
            img.status = STATUS_GEOM;
        else
        begin
            cyl = abs_lba[31:0] / per_cyl;
            rem = abs_lba[31:0] % per_cyl;
            hd  = rem / spt_cfg;
            sec = rem % spt_cfg + 1;
            img.status   = STATUS_OK;
            img.cylinder = cyl[9:0];
            img.head     = hd[7:0];
            img.sector   = sec[5:0];
            img.reg_ax   = {5'd0, op, cnt};
            img.reg_cx   = {cyl[7:0], cyl[9:8], sec[5:0]};
            img.reg_dx   = {hd[7:0], drive_cfg};
            img.reg_es   = seg;
            img.reg_bx   = off;
        end
        return img;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_cfg   <= RST_CYLINDERS;
            head_cfg  <= RST_HEADS;
            spt_cfg   <= RST_SPT;
            start_cfg <= '0;
            size_cfg  <= '0;
            drive_cfg <= RST_DRIVE;
            expected_chs_q.delete();
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CYLINDERS:  cyl_cfg   <= cfg_data[10:0];
                    CFG_HEADS:      head_cfg  <= cfg_data[8:0];
                    CFG_SPT:        spt_cfg   <= cfg_data[5:0];
                    CFG_PART_START: start_cfg <= cfg_data;
                    CFG_PART_SIZE:  size_cfg  <= cfg_data;
                    CFG_DRIVE:      drive_cfg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_chs_q.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    failures++;
                end
                else
                begin
                    oldest = expected_chs_q.pop_front();
                    check_field("status", oldest.status, status);
                    check_field("cylinder", oldest.cylinder, cylinder);
                    check_field("head", oldest.head, head);
                    check_field("sector", oldest.sector, sector);
                    check_field("reg_ax", oldest.reg_ax, reg_ax);
                    check_field("reg_cx", oldest.reg_cx, reg_cx);
                    check_field("reg_dx", oldest.reg_dx, reg_dx);
                    check_field("reg_es", oldest.reg_es, reg_es);
                    check_field("reg_bx", oldest.reg_bx, reg_bx);
                end
            end
            if (req_valid && req_ready)
                expected_chs_q.push_back(lba_to_chs_image(kind, block_address, sector_total,
                                                          buffer_segment, buffer_offset));
            pending <= expected_chs_q.size();
        end
    end

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Top of the LBA to CHS converter testbench: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
    import lbachs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // INT 13h operation codes placed in AH
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_VERIFY = 3'd4;
    // Index outside the register map; the block must ignore writes to it
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_PHASE      = 3;
    localparam int RSP_HOLD_CYCLES = 200;
    // Pipeline is 21 deep; the settle wait is longer than a pass through it
    localparam int SETTLE_CYCLES   = 30;
    localparam int TIMEOUT_NS      = 2_000_000;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_we         = 1'b0;
    logic [2:0]  cfg_index      = '0;
    logic [31:0] cfg_data       = '0;
    logic        req_valid      = 1'b0;
    logic        req_ready;
    logic [2:0]  kind           = '0;
    logic [31:0] block_address  = '0;
    logic [7:0]  sector_total   = '0;
    logic [15:0] buffer_segment = '0;
    logic [15:0] buffer_offset  = '0;
    logic        rsp_valid;
    logic        rsp_ready      = 1'b0;
    logic [1:0]  status;
    logic [9:0]  cylinder;
    logic [7:0]  head;
    logic [5:0]  sector;
    logic [15:0] reg_ax;
    logic [15:0] reg_cx;
    logic [15:0] reg_dx;
    logic [15:0] reg_es;
    logic [15:0] reg_bx;
    int          pending;
    int          failures;

    // Pacing knobs shared between the request and response processes
    bit tx_steady     = 1'b0;
    bit rx_steady     = 1'b0;
    bit rsp_hold_req  = 1'b0;

    // Random configuration scratch
    logic [31:0] cyl_v, head_v, spt_v, start_v, size_v;
    int unsigned cap;
    longint      room;
    int unsigned span;
    logic [31:0] lba_v;
    logic [7:0]  cnt_v;
    logic [2:0]  op_v;

    lba_to_chs_int13_request u_top (.*);

    chs_request_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Drive one register write; the enable stays up until close_writes
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] cyls, input logic [31:0] heads,
                              input logic [31:0] spt, input logic [31:0] start,
                              input logic [31:0] size, input logic [31:0] drive);
        write_reg(CFG_CYLINDERS, cyls);
        write_reg(CFG_HEADS, heads);
        write_reg(CFG_SPT, spt);
        write_reg(CFG_PART_START, start);
        write_reg(CFG_PART_SIZE, size);
        write_reg(CFG_DRIVE, drive);
        close_writes();
    endtask

    // Offer one request beat, after a random gap unless the sender runs steady
    task automatic send_req(input logic [2:0] op, input logic [31:0] lba,
                            input logic [7:0] cnt, input logic [15:0] seg,
                            input logic [15:0] off);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        kind           <= op;
        block_address  <= lba;
        sector_total   <= cnt;
        buffer_segment <= seg;
        buffer_offset  <= off;
        do @(posedge clk); while (!req_ready);
    endtask

    // Drop valid, wait for every expected response, then let the pipeline settle
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Randomly stuff the unused upper bits of a narrow register write
    function automatic logic [31:0] with_noise(input logic [31:0] v, input logic [31:0] mask);
        return ($urandom_range(0, 1) != 0) ? (v | ($urandom & ~mask)) : v;
    endfunction

    // Response side: a random stall before each beat, and one long hold-off
    // when the stimulus asks for it, so the pipeline backs up into the input.
    initial
    begin
        int stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rsp_hold_req)
            begin
                rsp_hold_req = 1'b0;
                rsp_ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry with a zero-size partition: only an empty request
        // at block zero passes the partition check.
        send_req(OP_READ, 32'd0, 8'd0, 16'h1234, 16'h5678);
        send_req(OP_WRITE, 32'd1, 8'd0, 16'h0000, 16'h0000);
        send_req(OP_VERIFY, 32'd0, 8'd1, 16'hFFFF, 16'hFFFF);
        drain_responses();

        // Standard 1024/16/63 disk, partition spans all of LBA space
        set_config(32'd1024, 32'd16, 32'd63, 32'd0, 32'hFFFF_FFFF, 32'h80);
        // Walk every operation code, the undefined ones included
        for (int op = 0; op < 8; op++)
            send_req(3'(op), 32'(op * 123457), 8'(op * 36), 16'(op * 9000),
                     16'hFFFF - 16'(op * 9000));
        // Last sector of the disk, then one past it
        send_req(OP_READ, 32'd1032191, 8'd255, 16'hFFFF, 16'hFFFF);
        send_req(OP_WRITE, 32'd1032192, 8'd1, 16'h0001, 16'h0002);
        // Top of LBA space: empty request passes the partition check only,
        // a single sector carries past 32 bits and fails it
        send_req(OP_VERIFY, 32'hFFFF_FFFF, 8'd0, 16'h0F0F, 16'hF0F0);
        send_req(OP_READ, 32'hFFFF_FFFF, 8'd1, 16'h0F0F, 16'hF0F0);
        // First sector of the second cylinder
        send_req(OP_WRITE, 32'd1008, 8'd255, 16'h8000, 16'h0001);
        drain_responses();

        // Oversized geometry clamps to 1024/256/63; upper data bits ignored,
        // drive number zero, plus a stray write to an unmapped index
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5,
                   32'h0100_0000, 32'hFFFF_FF00);
        write_reg(CFG_UNUSED, $urandom);
        close_writes();
        send_req(OP_READ, 32'd16515066, 8'd0, 16'hAAAA, 16'h5555);
        send_req(OP_READ, 32'd16515067, 8'd0, 16'hAAAA, 16'h5555);
        send_req(OP_WRITE, 32'h00FF_FFF6, 8'd10, 16'h5555, 16'hAAAA);
        send_req(OP_WRITE, 32'h00FF_FFF6, 8'd11, 16'h5555, 16'hAAAA);
        drain_responses();

        // Partition start near the top: the absolute address carries out
        set_config(32'd1024, 32'd16, 32'd63, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h55);
        send_req(OP_VERIFY, 32'h20, 8'd1, 16'h0100, 16'h0200);
        send_req(OP_READ, 32'hFFFF_FFFF, 8'd1, 16'h0100, 16'h0200);
        drain_responses();
        // Each zero geometry register alone forces a geometry failure
        write_reg(CFG_SPT, 32'd0);
        write_reg(CFG_PART_START, 32'd0);
        close_writes();
        send_req(OP_READ, 32'd0, 8'd1, 16'h0300, 16'h0400);
        drain_responses();
        write_reg(CFG_SPT, 32'd63);
        write_reg(CFG_CYLINDERS, 32'd0);
        close_writes();
        send_req(OP_WRITE, 32'd0, 8'd1, 16'h0300, 16'h0400);
        drain_responses();
        write_reg(CFG_CYLINDERS, 32'd1024);
        write_reg(CFG_HEADS, 32'd0);
        close_writes();
        send_req(OP_VERIFY, 32'd0, 8'd1, 16'h0300, 16'h0400);
        drain_responses();

        // Random phases: new geometry each time, requests mostly inside the
        // partition and the disk so the divider gets real work.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 15))
                0:       cyl_v = 32'd0;
                1:       cyl_v = $urandom_range(1025, 2047);
                2:       cyl_v = 32'd1024;
                default: cyl_v = $urandom_range(1, 1024);
            endcase
            case ($urandom_range(0, 15))
                0:       head_v = 32'd0;
                1:       head_v = $urandom_range(257, 511);
                2:       head_v = 32'd256;
                default: head_v = $urandom_range(1, 256);
            endcase
            case ($urandom_range(0, 15))
                0:       spt_v = 32'd0;
                1:       spt_v = 32'd63;
                default: spt_v = $urandom_range(1, 63);
            endcase
            cap = ((cyl_v > 1024) ? 1024 : cyl_v) * ((head_v > 256) ? 256 : head_v) * spt_v;
            case ($urandom_range(0, 5))
                0:       start_v = $urandom;
                1:       start_v = 32'd0;
                default: start_v = (cap == 0) ? $urandom_range(0, 100) : $urandom_range(0, cap / 2);
            endcase
            room = longint'(cap) - longint'(start_v);
            if (room < 0)
                room = 0;
            case ($urandom_range(0, 7))
                0:       size_v = $urandom;
                1:       size_v = $urandom_range(0, 1000);
                default: size_v = 32'(room) + $urandom_range(0, 300);
            endcase
            span = (room < longint'(size_v)) ? int'(room) : size_v;
            set_config(with_noise(cyl_v, 32'h7FF), with_noise(head_v, 32'h1FF),
                       with_noise(spt_v, 32'h3F), start_v, size_v,
                       with_noise($urandom_range(0, 255), 32'hFF));

            // Some phases run flat out on one side or both
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE)
            begin
                // Hold the response side while requests keep coming
                tx_steady    = 1'b1;
                rsp_hold_req = 1'b1;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       lba_v = $urandom;
                    1:       lba_v = span + $urandom_range(0, 16) - 8;
                    default: lba_v = (span == 0) ? $urandom_range(0, 16)
                                                 : $urandom_range(0, span - 1);
                endcase
                case ($urandom_range(0, 7))
                    0:       cnt_v = $urandom_range(0, 255);
                    1:       cnt_v = 8'd0;
                    default: cnt_v = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 9))
                    0:       op_v = $urandom_range(0, 7);
                    1, 2, 3: op_v = OP_READ;
                    4, 5, 6: op_v = OP_WRITE;
                    default: op_v = OP_VERIFY;
                endcase
                send_req(op_v, lba_v, cnt_v, $urandom_range(0, 65535),
                         $urandom_range(0, 65535));
            end
            drain_responses();
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        if (failures == 0)
            $display("lba_to_chs_int13_request verification clean");
        else
            $display("lba_to_chs_int13_request verification failed");
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("lba_to_chs_int13_request verification failed");
        $finish;
    end

endmodule
`default_nettype wire
